FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands clocked on a rising edge, with an active-low
// reset that disables checking.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: sv/dfa_pkg.sv
// ----------------------------------------------------------------------------
// dfa_pkg
// Widths, operation codes and shared types of the dual-format ALU.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dfa_pkg;

    localparam int WIDTH   = 8;
    localparam int FIELD_W = 8;
    localparam int MODE_W  = 4;
    localparam int VAL_W   = WIDTH + 2;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    typedef logic [FIELD_W-1:0]      t_field;
    typedef logic [WIDTH-1:0]        t_word;
    typedef logic signed [VAL_W-1:0] t_val;
    typedef logic [MODE_W-1:0]       t_mode;

    localparam t_mode MODE_NOT  = 4'd0;
    localparam t_mode MODE_ROTL = 4'd1;
    localparam t_mode MODE_ROTR = 4'd2;
    localparam t_mode MODE_AND  = 4'd3;
    localparam t_mode MODE_NAND = 4'd4;
    localparam t_mode MODE_OR   = 4'd5;
    localparam t_mode MODE_NOR  = 4'd6;
    localparam t_mode MODE_XOR  = 4'd7;
    localparam t_mode MODE_INC  = 4'd8;
    localparam t_mode MODE_DEC  = 4'd9;
    localparam t_mode MODE_NEG  = 4'd10;
    localparam t_mode MODE_ADD  = 4'd11;
    localparam t_mode MODE_SUB  = 4'd12;
    localparam t_mode MODE_CONV = 4'd13;

    localparam logic FMT_UNSIGNED = 1'b0;
    localparam logic FMT_SIGN_MAG = 1'b1;

    localparam logic REG_NUMBER_FORMAT = 1'b0;

    typedef struct packed {
        logic zero;
        logic sign;
        logic overflow;
        logic underflow;
    } t_flags;

endpackage

`default_nettype wire

FILE: sv/dfa_if.sv
// ----------------------------------------------------------------------------
// dfa_in_if / dfa_out_if
// Valid-ready channels that carry the instruction items and the result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dfa_in_if;
    logic           valid;
    logic           ready;
    dfa_pkg::t_mode mode;
    dfa_pkg::t_field operand_a;
    dfa_pkg::t_field operand_b;
    logic           source_format;
    logic           target_format;

    modport source (output valid, output mode, output operand_a, output operand_b,
                    output source_format, output target_format, input ready);
    modport sink   (input valid, input mode, input operand_a, input operand_b,
                    input source_format, input target_format, output ready);
endinterface

interface dfa_out_if;
    logic            valid;
    logic            ready;
    dfa_pkg::t_field result;
    logic            zero_flag;
    logic            sign_flag;
    logic            overflow_flag;
    logic            underflow_flag;

    modport source (output valid, output result, output zero_flag, output sign_flag,
                    output overflow_flag, output underflow_flag, input ready);
    modport sink   (input valid, input result, input zero_flag, input sign_flag,
                    input overflow_flag, input underflow_flag, output ready);
endinterface

`default_nettype wire

FILE: sv/dfa_exec.sv
// ----------------------------------------------------------------------------
// dfa_exec
// Combinational execute stage: decodes operands, computes the exact value,
// then wraps or saturates it and derives the next status flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dfa_exec (
    input  var dfa_pkg::t_mode  i_mode,
    input  var dfa_pkg::t_field i_operand_a,
    input  var dfa_pkg::t_field i_operand_b,
    input  var logic            i_source_format,
    input  var logic            i_target_format,
    input  var logic            i_number_format,
    input  var dfa_pkg::t_flags i_flags,
    output dfa_pkg::t_field     o_result,
    output dfa_pkg::t_flags     o_flags
);

    localparam int W  = dfa_pkg::WIDTH;
    localparam int VW = dfa_pkg::VAL_W;
    localparam dfa_pkg::t_val SM_MAX = VW'((1 << (W - 1)) - 1);
    localparam dfa_pkg::t_val U_MAX  = VW'((1 << W) - 1);

    function automatic dfa_pkg::t_val decode_word(input dfa_pkg::t_word w, input logic fmt);
        dfa_pkg::t_val mag;
        mag = VW'(w[W-2:0]);
        if (fmt == dfa_pkg::FMT_UNSIGNED) begin
            return VW'(w);
        end
        return w[W-1] ? -mag : mag;
    endfunction

    dfa_pkg::t_word a;
    dfa_pkg::t_word b;
    dfa_pkg::t_word logic_w;
    dfa_pkg::t_word res;
    dfa_pkg::t_val  v;
    dfa_pkg::t_val  mag;
    logic           is_logic;
    logic           is_arith;
    logic           chk_fmt;

    assign a = i_operand_a[W-1:0];
    assign b = i_operand_b[W-1:0];

    always_comb begin
        logic_w  = '0;
        v        = '0;
        is_logic = 1'b0;
        is_arith = 1'b0;
        chk_fmt  = i_number_format;
        case (i_mode)
            dfa_pkg::MODE_NOT: begin
                logic_w  = ~a;
                is_logic = 1'b1;
            end
            dfa_pkg::MODE_ROTL: begin
                logic_w  = {a[W-2:0], a[W-1]};
                is_logic = 1'b1;
            end
            dfa_pkg::MODE_ROTR: begin
                logic_w  = {a[0], a[W-1:1]};
                is_logic = 1'b1;
            end
            dfa_pkg::MODE_AND: begin
                logic_w  = a & b;
                is_logic = 1'b1;
            end
            dfa_pkg::MODE_NAND: begin
                logic_w  = ~(a & b);
                is_logic = 1'b1;
            end
            dfa_pkg::MODE_OR: begin
                logic_w  = a | b;
                is_logic = 1'b1;
            end
            dfa_pkg::MODE_NOR: begin
                logic_w  = ~(a | b);
                is_logic = 1'b1;
            end
            dfa_pkg::MODE_XOR: begin
                logic_w  = a ^ b;
                is_logic = 1'b1;
            end
            dfa_pkg::MODE_INC: begin
                v        = decode_word(a, i_number_format) + VW'(1);
                is_arith = 1'b1;
            end
            dfa_pkg::MODE_DEC: begin
                v        = decode_word(a, i_number_format) - VW'(1);
                is_arith = 1'b1;
            end
            dfa_pkg::MODE_NEG: begin
                v        = -decode_word(a, i_number_format);
                is_arith = 1'b1;
            end
            dfa_pkg::MODE_ADD: begin
                v        = decode_word(a, i_number_format) + decode_word(b, i_number_format);
                is_arith = 1'b1;
            end
            dfa_pkg::MODE_SUB: begin
                v        = decode_word(a, i_number_format) - decode_word(b, i_number_format);
                is_arith = 1'b1;
            end
            dfa_pkg::MODE_CONV: begin
                v        = decode_word(a, i_source_format);
                chk_fmt  = i_target_format;
                is_arith = 1'b1;
            end
            default: begin
                logic_w = '0;
            end
        endcase
    end

    always_comb begin
        o_flags = i_flags;
        res     = '0;
        mag     = (v < 0) ? -v : v;
        if (is_logic) begin
            res          = logic_w;
            o_flags.zero = (logic_w == '0);
        end else if (is_arith) begin
            o_flags.zero = (v == 0);
            o_flags.sign = (v < 0);
            if (chk_fmt == dfa_pkg::FMT_UNSIGNED) begin
                o_flags.overflow  = (v > U_MAX);
                o_flags.underflow = (v < 0);
                res               = v[W-1:0];
            end else begin
                o_flags.overflow  = (v > SM_MAX);
                o_flags.underflow = (v < -SM_MAX);
                if ((v > SM_MAX) || (v < -SM_MAX)) begin
                    mag = SM_MAX;
                end
                res = {v < 0, mag[W-2:0]};
            end
        end
    end

    assign o_result = dfa_pkg::t_field'(res);

endmodule

`default_nettype wire

FILE: sv/dual_format_alu_with_flags_core.sv
// ----------------------------------------------------------------------------
// dual_format_alu_with_flags_core
// WIDTH-bit ALU with logical and arithmetic operations in unsigned wrapping or
// sign-magnitude saturating format, with held status flags.
// ----------------------------------------------------------------------------
// An accepted input item goes into the input register, then through the execute logic
// into the result register, where it is offered on the output channel.
// Throughput: one item per cycle; the two-stage register pipeline stalls only
// when the result register is full and not being taken.
// Reset clears both valid bits, the held flags and the number format.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dual_format_alu_with_flags_core (
    input  var logic                        i_clk,
    input  var logic                        i_rst_n,
    dfa_in_if.sink                          in_ch,
    dfa_out_if.source                       out_ch,
    input  var logic                        psel,
    input  var logic                        penable,
    input  var logic                        pwrite,
    input  var logic [dfa_pkg::APB_AW-1:0]  paddr,
    input  var logic [dfa_pkg::APB_DW-1:0]  pwdata,
    output logic     [dfa_pkg::APB_DW-1:0]  prdata,
    output logic                            pready
);

    logic            r_number_format;
    logic            r_in_valid;
    dfa_pkg::t_mode  r_mode;
    dfa_pkg::t_field r_operand_a;
    dfa_pkg::t_field r_operand_b;
    logic            r_source_format;
    logic            r_target_format;
    logic            r_out_valid;
    dfa_pkg::t_field r_result;
    dfa_pkg::t_flags r_flags;

    dfa_pkg::t_field n_result;
    dfa_pkg::t_flags n_flags;
    logic            out_free;
    logic            in_adv;
    logic            in_take;
    logic            cfg_wr;
    logic            logic_adv;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready
                      && (paddr[2] == dfa_pkg::REG_NUMBER_FORMAT);
    assign prdata   = (paddr[2] == dfa_pkg::REG_NUMBER_FORMAT)
                      ? dfa_pkg::APB_DW'(r_number_format) : '0;

    assign out_free    = !r_out_valid || out_ch.ready;
    assign in_adv      = r_in_valid && out_free;
    assign in_ch.ready = !r_in_valid || out_free;
    assign in_take     = in_ch.valid && in_ch.ready;
    assign logic_adv   = in_adv && (r_mode < dfa_pkg::MODE_INC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number_format <= dfa_pkg::FMT_UNSIGNED;
        end else if (cfg_wr) begin
            r_number_format <= pwdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ch.ready) begin
            r_in_valid <= in_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_mode          <= in_ch.mode;
            r_operand_a     <= in_ch.operand_a;
            r_operand_b     <= in_ch.operand_b;
            r_source_format <= in_ch.source_format;
            r_target_format <= in_ch.target_format;
        end
    end

    dfa_exec u_exec (
        .i_mode          (r_mode),
        .i_operand_a     (r_operand_a),
        .i_operand_b     (r_operand_b),
        .i_source_format (r_source_format),
        .i_target_format (r_target_format),
        .i_number_format (r_number_format),
        .i_flags         (r_flags),
        .o_result        (n_result),
        .o_flags         (n_flags)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_flags     <= '0;
        end else begin
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (in_adv) begin
                r_flags <= n_flags;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_adv) begin
            r_result <= n_result;
        end
    end

    assign out_ch.valid          = r_out_valid;
    assign out_ch.result         = r_result;
    assign out_ch.zero_flag      = r_flags.zero;
    assign out_ch.sign_flag      = r_flags.sign;
    assign out_ch.overflow_flag  = r_flags.overflow;
    assign out_ch.underflow_flag = r_flags.underflow;

    // A logical operation must leave the sign, overflow and underflow flags untouched.
    `ASSERT_NXT(a_logic_keeps_flags, i_clk, i_rst_n, logic_adv, $stable(r_flags[2:0]))
    // A value below the format minimum is always negative.
    `ASSERT_IMP(a_underflow_is_negative, i_clk, i_rst_n, r_flags.underflow, r_flags.sign)
    // The input side stalls only when both stages hold an item.
    `ASSERT_IMP(a_stall_only_when_full, i_clk, i_rst_n, !in_ch.ready, r_in_valid && r_out_valid)

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the dual-format ALU core against its own model of the operations,
// the number formats and the held flags. A directed table covers the corner
// cases first. Random instruction items follow in phases that switch the
// number format over the APB port. Idle cycles are inserted at random on both
// channels. Results are compared field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
    import dfa_pkg::*;

    localparam int   WATCHDOG_LIMIT    = 4000;
    localparam int   RANDOM_PHASES     = 6;
    localparam int   ITEMS_PER_PHASE   = 213;
    localparam t_mode MODE_SPARE_14    = 4'd14;
    localparam t_mode MODE_SPARE_15    = 4'd15;
    localparam logic [APB_AW-1:0] ADDR_NUMBER_FORMAT = APB_AW'(4 * REG_NUMBER_FORMAT);

    typedef struct packed {
        t_mode mode;
        t_word operand_a;
        t_word operand_b;
        logic  source_format;
        logic  target_format;
    } alu_instr_t;

    typedef struct packed {
        t_word  result;
        t_flags flags;
    } alu_result_t;

    typedef struct packed {
        logic   number_format;
        t_mode  mode;
        t_word  operand_a;
        t_word  operand_b;
        logic   source_format;
        logic   target_format;
        logic   known;
        t_word  result;
        t_flags flags;
    } directed_row_t;

    // Flags are written as zero, sign, overflow, underflow.
    localparam directed_row_t DIRECTED_ROWS [25] = '{
        '{FMT_UNSIGNED, MODE_ROTL,     8'h00, 8'h00, 1'b0, 1'b0, 1'b1, 8'h00, t_flags'(4'b1000)},
        '{FMT_UNSIGNED, MODE_NOT,      8'h00, 8'h00, 1'b0, 1'b0, 1'b1, 8'hFF, t_flags'(4'b0000)},
        '{FMT_UNSIGNED, MODE_ROTR,     8'h01, 8'hFF, 1'b0, 1'b0, 1'b0, 8'h00, t_flags'(4'b0000)},
        '{FMT_UNSIGNED, MODE_ROTL,     8'h80, 8'h00, 1'b1, 1'b1, 1'b0, 8'h00, t_flags'(4'b0000)},
        '{FMT_UNSIGNED, MODE_AND,      8'hFF, 8'hFF, 1'b0, 1'b0, 1'b0, 8'h00, t_flags'(4'b0000)},
        '{FMT_UNSIGNED, MODE_NAND,     8'hFF, 8'hFF, 1'b0, 1'b0, 1'b0, 8'h00, t_flags'(4'b0000)},
        '{FMT_UNSIGNED, MODE_OR,       8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00, t_flags'(4'b0000)},
        '{FMT_UNSIGNED, MODE_NOR,      8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00, t_flags'(4'b0000)},
        '{FMT_UNSIGNED, MODE_XOR,      8'hAA, 8'h55, 1'b0, 1'b0, 1'b0, 8'h00, t_flags'(4'b0000)},
        '{FMT_UNSIGNED, MODE_INC,      8'hFF, 8'h00, 1'b0, 1'b0, 1'b1, 8'h00, t_flags'(4'b0010)},
        '{FMT_UNSIGNED, MODE_DEC,      8'h00, 8'h00, 1'b0, 1'b0, 1'b1, 8'hFF, t_flags'(4'b0101)},
        '{FMT_UNSIGNED, MODE_ADD,      8'hFF, 8'hFF, 1'b0, 1'b0, 1'b1, 8'hFE, t_flags'(4'b0010)},
        '{FMT_UNSIGNED, MODE_SUB,      8'h00, 8'hFF, 1'b0, 1'b0, 1'b1, 8'h01, t_flags'(4'b0101)},
        '{FMT_UNSIGNED, MODE_NEG,      8'h00, 8'h00, 1'b0, 1'b0, 1'b1, 8'h00, t_flags'(4'b1000)},
        '{FMT_UNSIGNED, MODE_SPARE_14, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b0, 8'h00, t_flags'(4'b0000)},
        '{FMT_UNSIGNED, MODE_SPARE_15, 8'h5A, 8'hA5, 1'b0, 1'b1, 1'b0, 8'h00, t_flags'(4'b0000)},
        '{FMT_UNSIGNED, MODE_CONV,     8'h85, 8'h00, 1'b1, 1'b0, 1'b1, 8'hFB, t_flags'(4'b0101)},
        '{FMT_UNSIGNED, MODE_CONV,     8'hFB, 8'h00, 1'b0, 1'b1, 1'b1, 8'h7F, t_flags'(4'b0010)},
        '{FMT_UNSIGNED, MODE_CONV,     8'h80, 8'h00, 1'b1, 1'b1, 1'b1, 8'h00, t_flags'(4'b1000)},
        '{FMT_SIGN_MAG, MODE_INC,      8'h7F, 8'h00, 1'b0, 1'b0, 1'b1, 8'h7F, t_flags'(4'b0010)},
        '{FMT_SIGN_MAG, MODE_DEC,      8'hFF, 8'h00, 1'b0, 1'b0, 1'b1, 8'hFF, t_flags'(4'b0101)},
        '{FMT_SIGN_MAG, MODE_ADD,      8'h80, 8'h80, 1'b0, 1'b0, 1'b1, 8'h00, t_flags'(4'b1000)},
        '{FMT_SIGN_MAG, MODE_SUB,      8'h7F, 8'hFF, 1'b0, 1'b0, 1'b1, 8'h7F, t_flags'(4'b0010)},
        '{FMT_SIGN_MAG, MODE_NEG,      8'h85, 8'h00, 1'b0, 1'b0, 1'b1, 8'h05, t_flags'(4'b0000)},
        '{FMT_SIGN_MAG, MODE_ADD,      8'hFF, 8'hFF, 1'b0, 1'b0, 1'b1, 8'hFF, t_flags'(4'b0101)}
    };

    localparam t_word CORNER_WORDS [7] = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'h81, 8'hFE, 8'hFF};

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    dfa_in_if  in_ch ();
    dfa_out_if out_ch ();

    dual_format_alu_with_flags_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    alu_result_t pending_results [$];
    logic        fmt_model;
    t_flags      held_model;
    logic        steady_flow;
    int          mismatch_count = 0;
    int          idle_cycles    = 0;
    int          stall_left     = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (steady_flow || roll < 60) return 0;
        if (roll < 88) return $urandom_range(3, 1);
        if (roll < 97) return $urandom_range(12, 4);
        return $urandom_range(40, 20);
    endfunction

    function automatic t_word pick_word();
        if ($urandom_range(3) == 0) return CORNER_WORDS[$urandom_range(6)];
        return t_word'($urandom_range(255));
    endfunction

    function automatic alu_instr_t random_instr();
        alu_instr_t op;
        if ($urandom_range(99) < 3) begin
            op.mode = $urandom_range(1) ? MODE_SPARE_14 : MODE_SPARE_15;
        end else begin
            op.mode = t_mode'($urandom_range(MODE_CONV));
        end
        op.operand_a     = pick_word();
        op.operand_b     = pick_word();
        op.source_format = 1'($urandom_range(1));
        op.target_format = 1'($urandom_range(1));
        return op;
    endfunction

    function automatic int decode_word(t_word w, logic fmt);
        int mag;
        mag = int'(w[WIDTH-2:0]);
        if (fmt == FMT_UNSIGNED) return int'(w);
        return w[WIDTH-1] ? -mag : mag;
    endfunction

    function automatic t_word settle_value(int v, logic fmt);
        int limit;
        limit = (1 << (WIDTH - 1)) - 1;
        held_model.zero = (v == 0);
        held_model.sign = (v < 0);
        if (fmt == FMT_UNSIGNED) begin
            held_model.overflow  = (v > (1 << WIDTH) - 1);
            held_model.underflow = (v < 0);
            if (v < 0) v += 1 << WIDTH;
            if (v < 0) v = 0;
            return t_word'(v);
        end
        held_model.overflow = (v > limit);
        if (v > limit) v = limit;
        held_model.underflow = (v < -limit);
        if (v < -limit) v = limit;
        if (v < 0) v = -v;
        return {held_model.sign, v[WIDTH-2:0]};
    endfunction

    function automatic alu_result_t compute_alu_result(alu_instr_t op);
        alu_result_t res;
        t_word       a;
        t_word       b;
        t_word       r;
        logic        logical;
        a       = op.operand_a[WIDTH-1:0];
        b       = op.operand_b[WIDTH-1:0];
        logical = 1'b1;
        r       = '0;
        case (op.mode)
            MODE_NOT:  r = ~a;
            MODE_ROTL: r = {a[WIDTH-2:0], a[WIDTH-1]};
            MODE_ROTR: r = {a[0], a[WIDTH-1:1]};
            MODE_AND:  r = a & b;
            MODE_NAND: r = ~(a & b);
            MODE_OR:   r = a | b;
            MODE_NOR:  r = ~(a | b);
            MODE_XOR:  r = a ^ b;
            default:   logical = 1'b0;
        endcase
        case (op.mode)
            MODE_INC:  r = settle_value(decode_word(a, fmt_model) + 1, fmt_model);
            MODE_DEC:  r = settle_value(decode_word(a, fmt_model) - 1, fmt_model);
            MODE_NEG:  r = settle_value(-decode_word(a, fmt_model), fmt_model);
            MODE_ADD:  r = settle_value(decode_word(a, fmt_model) + decode_word(b, fmt_model),
                                        fmt_model);
            MODE_SUB:  r = settle_value(decode_word(a, fmt_model) - decode_word(b, fmt_model),
                                        fmt_model);
            MODE_CONV: r = settle_value(decode_word(a, op.source_format), op.target_format);
            default: begin
            end
        endcase
        if (logical) held_model.zero = (r == '0);
        res.result = r;
        res.flags  = held_model;
        return res;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    task automatic send_instr(alu_instr_t op, logic known, alu_result_t typed);
        alu_result_t predicted;
        int          gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.mode          <= op.mode;
        in_ch.operand_a     <= t_field'(op.operand_a);
        in_ch.operand_b     <= t_field'(op.operand_b);
        in_ch.source_format <= op.source_format;
        in_ch.target_format <= op.target_format;
        do @(posedge i_clk); while (!in_ch.ready);
        predicted = compute_alu_result(op);
        pending_results.push_back(known ? typed : predicted);
    endtask

    task automatic apb_access(input logic wr, input logic [APB_DW-1:0] wdata,
                              output logic [APB_DW-1:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_NUMBER_FORMAT;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_format(logic fmt);
        logic [APB_DW-1:0] readback;
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        apb_access(1'b1, APB_DW'(fmt), readback);
        fmt_model = fmt;
        apb_access(1'b0, '0, readback);
        check_field("number_format", int'(fmt), int'(readback[0]));
    endtask

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            out_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else begin
            out_ch.ready <= 1'b1;
            stall_left   <= pick_gap();
        end
    end

    always @(posedge i_clk) begin : result_check
        alu_result_t want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result item: expected none actual %0h",
                         $time, out_ch.result);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("result", int'(want.result), int'(out_ch.result));
                check_field("zero_flag", int'(want.flags.zero), int'(out_ch.zero_flag));
                check_field("sign_flag", int'(want.flags.sign), int'(out_ch.sign_flag));
                check_field("overflow_flag", int'(want.flags.overflow),
                            int'(out_ch.overflow_flag));
                check_field("underflow_flag", int'(want.flags.underflow),
                            int'(out_ch.underflow_flag));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (psel && penable && pready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        alu_instr_t  op;
        alu_result_t typed;
        i_rst_n             <= 1'b0;
        in_ch.valid         <= 1'b0;
        in_ch.mode          <= MODE_NOT;
        in_ch.operand_a     <= '0;
        in_ch.operand_b     <= '0;
        in_ch.source_format <= FMT_UNSIGNED;
        in_ch.target_format <= FMT_UNSIGNED;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        fmt_model   = FMT_UNSIGNED;
        held_model  = '0;
        steady_flow = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED_ROWS[i]) begin
            if (DIRECTED_ROWS[i].number_format != fmt_model) begin
                set_format(DIRECTED_ROWS[i].number_format);
            end
            op.mode          = DIRECTED_ROWS[i].mode;
            op.operand_a     = DIRECTED_ROWS[i].operand_a;
            op.operand_b     = DIRECTED_ROWS[i].operand_b;
            op.source_format = DIRECTED_ROWS[i].source_format;
            op.target_format = DIRECTED_ROWS[i].target_format;
            typed.result     = DIRECTED_ROWS[i].result;
            typed.flags      = DIRECTED_ROWS[i].flags;
            send_instr(op, DIRECTED_ROWS[i].known, typed);
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            set_format(phase % 2 == 0 ? FMT_UNSIGNED : FMT_SIGN_MAG);
            steady_flow = (phase == 3);
            repeat (ITEMS_PER_PHASE) send_instr(random_instr(), 1'b0, typed);
        end

        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
